>>> design/bgr_pkg.sv
// package: constants, types and helpers of the bilinear grid resampler
package bgr_pkg;

  localparam int MAX_SRC_W = 256;
  localparam int MAX_SRC_H = 256;
  localparam int FRAC_BITS = 16;

  localparam int SW_W     = 9;
  localparam int DW_W     = 13;
  localparam int COORD_W  = 12;
  localparam int VAL_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam int COL_W    = $clog2(MAX_SRC_W);
  localparam int ROW_W    = $clog2(MAX_SRC_H);
  localparam int BANK_AW  = (COL_W - 1) + (ROW_W - 1);
  localparam int BANK_DEPTH = 2 ** BANK_AW;
  localparam int N_BANKS  = 4;

  localparam int RATIO_W  = SW_W + FRAC_BITS;
  localparam int CNT_W    = $clog2(RATIO_W);
  localparam int SX_W     = COORD_W + RATIO_W;
  localparam int INT_W    = SX_W - FRAC_BITS;
  localparam int W_W      = FRAC_BITS + 1;
  localparam int PROD_W   = VAL_W + W_W + 1;
  localparam int SUM_W    = PROD_W + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_H = 3'd3;

  localparam logic CMD_LOAD = 1'b0;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_RUN
  } div_state_e;

  function automatic logic [SW_W-1:0] clamp_size(input logic [SW_W-1:0] v,
                                                 input logic [SW_W-1:0] max_v);
    logic [SW_W-1:0] r;
    if (v == '0) r = SW_W'(1);
    else if (v > max_v) r = max_v;
    else r = v;
    return r;
  endfunction

endpackage

>>> design/bilinear_grid_resampler_top.sv
// top level: banked grid store, ratio divider and the bilinear pixel pipeline
// One item enters per clock while in_stall_o is low. A pixel request passes the
// input register, multiply, clamp, banked store read and weights, four products,
// two adder levels and the output register; stalls on the output back up stage by
// stage. Loads take no output slot and write the store at stage 3, where the reads
// are made, so reads and writes keep item order. The grid store is four
// banks split by row and column parity, so the four neighbours come out in
// one read. After each write to a size register the two size ratios are rebuilt by
// a shared-step restoring divider, during which the input and
// the configuration port are stalled.
module bilinear_grid_resampler_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bgr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bgr_pkg::DW_W-1:0]             cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 command_i,
  input  logic [bgr_pkg::COORD_W-1:0]          coord_x_i,
  input  logic [bgr_pkg::COORD_W-1:0]          coord_y_i,
  input  logic signed [bgr_pkg::VAL_W-1:0]     sample_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [bgr_pkg::VAL_W-1:0]     pixel_value_o,
  output logic [bgr_pkg::COORD_W-1:0]          pixel_x_o,
  output logic [bgr_pkg::COORD_W-1:0]          pixel_y_o
);

  localparam int CW = bgr_pkg::COORD_W;
  localparam int VW = bgr_pkg::VAL_W;
  localparam int FB = bgr_pkg::FRAC_BITS;
  localparam int RW = bgr_pkg::RATIO_W;
  localparam int DW = bgr_pkg::DW_W;
  localparam int SW = bgr_pkg::SW_W;

  // configuration and ratio divider
  logic [SW-1:0] src_w_q, src_h_q;
  logic [DW-1:0] dst_w_q, dst_h_q;
  logic [RW-1:0] ratio_x_q, ratio_y_q;
  logic [RW-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [DW:0]   rx_q, rx_d, ry_q, ry_d;
  logic [bgr_pkg::CNT_W-1:0] cnt_q;
  bgr_pkg::div_state_e div_state_q, div_state_d;
  logic div_busy, cfg_wr, cfg_hit;
  logic [SW-1:0] sw_eff, sh_eff;
  logic [DW-1:0] dw_eff, dh_eff;
  logic [DW:0]   tx, ty;
  logic          bx, by;

  assign sw_eff = bgr_pkg::clamp_size(src_w_q, SW'(bgr_pkg::MAX_SRC_W));
  assign sh_eff = bgr_pkg::clamp_size(src_h_q, SW'(bgr_pkg::MAX_SRC_H));
  assign dw_eff = (dst_w_q == '0) ? DW'(1) : dst_w_q;
  assign dh_eff = (dst_h_q == '0) ? DW'(1) : dst_h_q;

  assign cfg_wr = cfg_valid_i && cfg_ready_o;
  assign cfg_hit = cfg_index_i inside {bgr_pkg::CFG_SRC_W, bgr_pkg::CFG_SRC_H,
                                       bgr_pkg::CFG_DST_W, bgr_pkg::CFG_DST_H};

  always_comb begin
    div_state_d = div_state_q;
    case (div_state_q)
      bgr_pkg::DIV_IDLE: if (cfg_wr && cfg_hit) div_state_d = bgr_pkg::DIV_LOAD;
      bgr_pkg::DIV_LOAD: div_state_d = bgr_pkg::DIV_RUN;
      bgr_pkg::DIV_RUN: begin
        if (cnt_q == bgr_pkg::CNT_W'(RW - 1)) div_state_d = bgr_pkg::DIV_IDLE;
      end
      default: div_state_d = bgr_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    div_busy = (div_state_q != bgr_pkg::DIV_IDLE);
    cfg_ready_o = !div_busy;
  end

  // one restoring step for each ratio
  always_comb begin
    tx = {rx_q[DW-1:0], qx_q[RW-1]};
    ty = {ry_q[DW-1:0], qy_q[RW-1]};
    bx = (tx >= {1'b0, dw_eff});
    by = (ty >= {1'b0, dh_eff});
    rx_d = bx ? tx - {1'b0, dw_eff} : tx;
    ry_d = by ? ty - {1'b0, dh_eff} : ty;
    qx_d = {qx_q[RW-2:0], bx};
    qy_d = {qy_q[RW-2:0], by};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= bgr_pkg::DIV_IDLE;
      src_w_q <= SW'(256);
      src_h_q <= SW'(256);
      dst_w_q <= DW'(256);
      dst_h_q <= DW'(256);
      ratio_x_q <= RW'(1) << FB;
      ratio_y_q <= RW'(1) << FB;
      cnt_q <= '0;
    end else begin
      div_state_q <= div_state_d;
      if (cfg_wr) begin
        case (cfg_index_i)
          bgr_pkg::CFG_SRC_W: src_w_q <= cfg_data_i[SW-1:0];
          bgr_pkg::CFG_SRC_H: src_h_q <= cfg_data_i[SW-1:0];
          bgr_pkg::CFG_DST_W: dst_w_q <= cfg_data_i;
          bgr_pkg::CFG_DST_H: dst_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (div_state_q == bgr_pkg::DIV_LOAD) begin
        cnt_q <= '0;
      end else if (div_state_q == bgr_pkg::DIV_RUN) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == bgr_pkg::CNT_W'(RW - 1)) begin
          ratio_x_q <= qx_d;
          ratio_y_q <= qy_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_state_q == bgr_pkg::DIV_LOAD) begin
      qx_q <= {sw_eff, FB'(0)};
      qy_q <= {sh_eff, FB'(0)};
      rx_q <= '0;
      ry_q <= '0;
    end else if (div_state_q == bgr_pkg::DIV_RUN) begin
      qx_q <= qx_d;
      qy_q <= qy_d;
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
  end

  // pipeline control: stage k moves when empty or when k+1 moves
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic en1, en2, en3, en4, en5, en6, en7;
  logic accept;

  assign en7 = !v7_q || !out_stall_i;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1 || div_busy;
  assign accept = in_valid_i && !in_stall_o;

  // stage payloads
  logic          ld1_q, ld2_q, ld3_q;
  logic [CW-1:0] cx1_q, cy1_q, cx2_q, cy2_q, cx3_q, cy3_q, cx4_q, cy4_q;
  logic [CW-1:0] cx5_q, cy5_q, cx6_q, cy6_q, cx7_q, cy7_q;
  logic [VW-1:0] smp1_q, smp2_q, smp3_q;
  logic [bgr_pkg::SX_W-1:0] sx2_q, sy2_q;
  logic [bgr_pkg::COL_W-1:0] x0_3_q, x1_3_q;
  logic [bgr_pkg::ROW_W-1:0] y0_3_q, y1_3_q;
  logic [FB-1:0] fx3_q, fy3_q;
  logic [3:0]    par4_q;
  logic [bgr_pkg::W_W-1:0] w4_q [4];
  logic [bgr_pkg::W_W-1:0] w_d [4];
  logic signed [bgr_pkg::PROD_W-1:0] p5_q [4];
  logic signed [bgr_pkg::SUM_W-1:0]  s6_q [2];
  logic signed [bgr_pkg::SUM_W-1:0]  sum7;
  logic signed [VW-1:0] pix7_q;
  logic [VW-1:0] bank_rd_q [bgr_pkg::N_BANKS];

  // clamp of the integer texel position
  logic [bgr_pkg::INT_W-1:0] x0_raw, y0_raw;
  logic [bgr_pkg::COL_W-1:0] x_lim, x0_c, x1_c;
  logic [bgr_pkg::ROW_W-1:0] y_lim, y0_c, y1_c;
  always_comb begin
    x0_raw = sx2_q[bgr_pkg::SX_W-1:FB];
    y0_raw = sy2_q[bgr_pkg::SX_W-1:FB];
    x_lim = bgr_pkg::COL_W'(sw_eff - 1'b1);
    y_lim = bgr_pkg::ROW_W'(sh_eff - 1'b1);
    x0_c = (x0_raw > bgr_pkg::INT_W'(x_lim)) ? x_lim : x0_raw[bgr_pkg::COL_W-1:0];
    y0_c = (y0_raw > bgr_pkg::INT_W'(y_lim)) ? y_lim : y0_raw[bgr_pkg::ROW_W-1:0];
    x1_c = (x0_c == x_lim) ? x0_c : x0_c + 1'b1;
    y1_c = (y0_c == y_lim) ? y0_c : y0_c + 1'b1;
  end

  // weights: order is 00, 01 (next row), 10 (next column), 11
  logic [bgr_pkg::W_W-1:0] wx0, wy0, fxw, fyw;
  logic [2*bgr_pkg::W_W-1:0] m00, m01, m10, m11;
  always_comb begin
    fxw = {1'b0, fx3_q};
    fyw = {1'b0, fy3_q};
    wx0 = (bgr_pkg::W_W'(1) << FB) - fxw;
    wy0 = (bgr_pkg::W_W'(1) << FB) - fyw;
    m00 = wx0 * wy0;
    m01 = wx0 * fyw;
    m10 = fxw * wy0;
    m11 = fxw * fyw;
    w_d[0] = m00[FB +: bgr_pkg::W_W];
    w_d[1] = m01[FB +: bgr_pkg::W_W];
    w_d[2] = m10[FB +: bgr_pkg::W_W];
    w_d[3] = m11[FB +: bgr_pkg::W_W];
  end

  // store access at stage 3
  logic load_wr, req_rd, in_grid;
  logic [1:0] wr_bank;
  logic [bgr_pkg::BANK_AW-1:0] wr_addr;
  assign in_grid = (cx3_q < CW'(bgr_pkg::MAX_SRC_W)) && (cy3_q < CW'(bgr_pkg::MAX_SRC_H));
  assign load_wr = v3_q && ld3_q && en4 && in_grid;
  assign req_rd  = v3_q && !ld3_q && en4;
  assign wr_bank = {cy3_q[0], cx3_q[0]};
  assign wr_addr = {cy3_q[bgr_pkg::ROW_W-1:1], cx3_q[bgr_pkg::COL_W-1:1]};

  for (genvar gb = 0; gb < bgr_pkg::N_BANKS; gb++) begin : g_bank
    logic [VW-1:0] mem [bgr_pkg::BANK_DEPTH];
    logic [bgr_pkg::COL_W-1:0] col;
    logic [bgr_pkg::ROW_W-1:0] row;
    logic [bgr_pkg::BANK_AW-1:0] raddr;
    always_comb begin
      col = (x0_3_q[0] == 1'(gb % 2)) ? x0_3_q : x1_3_q;
      row = (y0_3_q[0] == 1'(gb / 2)) ? y0_3_q : y1_3_q;
      raddr = {row[bgr_pkg::ROW_W-1:1], col[bgr_pkg::COL_W-1:1]};
    end
    always_ff @(posedge clk_i) begin
      if (load_wr && (wr_bank == 2'(gb))) mem[wr_addr] <= smp3_q;
      if (req_rd) bank_rd_q[gb] <= mem[raddr];
    end
  end

  // neighbour selection by parity
  logic [VW-1:0] nb [4];
  always_comb begin
    nb[0] = bank_rd_q[{par4_q[2], par4_q[0]}];
    nb[1] = bank_rd_q[{par4_q[3], par4_q[0]}];
    nb[2] = bank_rd_q[{par4_q[2], par4_q[1]}];
    nb[3] = bank_rd_q[{par4_q[3], par4_q[1]}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
    end else begin
      if (en1) v1_q <= accept;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q && !ld3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  // second adder level; the output keeps bits FB and up of the sum, which floors it by 2**FB and keeps the sign
  assign sum7 = s6_q[0] + s6_q[1];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ld1_q  <= (command_i == bgr_pkg::CMD_LOAD);
      cx1_q  <= coord_x_i;
      cy1_q  <= coord_y_i;
      smp1_q <= sample_value_i;
    end
    if (en2) begin
      ld2_q  <= ld1_q;
      cx2_q  <= cx1_q;
      cy2_q  <= cy1_q;
      smp2_q <= smp1_q;
      sx2_q  <= cx1_q * ratio_x_q;
      sy2_q  <= cy1_q * ratio_y_q;
    end
    if (en3) begin
      ld3_q  <= ld2_q;
      cx3_q  <= cx2_q;
      cy3_q  <= cy2_q;
      smp3_q <= smp2_q;
      x0_3_q <= x0_c;
      x1_3_q <= x1_c;
      y0_3_q <= y0_c;
      y1_3_q <= y1_c;
      fx3_q  <= sx2_q[FB-1:0];
      fy3_q  <= sy2_q[FB-1:0];
    end
    if (en4) begin
      cx4_q  <= cx3_q;
      cy4_q  <= cy3_q;
      par4_q <= {y1_3_q[0], y0_3_q[0], x1_3_q[0], x0_3_q[0]};
      for (int i = 0; i < 4; i++) w4_q[i] <= w_d[i];
    end
    if (en5) begin
      cx5_q <= cx4_q;
      cy5_q <= cy4_q;
      for (int i = 0; i < 4; i++) begin
        p5_q[i] <= $signed(nb[i]) * $signed({1'b0, w4_q[i]});
      end
    end
    if (en6) begin
      cx6_q <= cx5_q;
      cy6_q <= cy5_q;
      s6_q[0] <= bgr_pkg::SUM_W'(p5_q[0]) + bgr_pkg::SUM_W'(p5_q[1]);
      s6_q[1] <= bgr_pkg::SUM_W'(p5_q[2]) + bgr_pkg::SUM_W'(p5_q[3]);
    end
    if (en7) begin
      cx7_q  <= cx6_q;
      cy7_q  <= cy6_q;
      pix7_q <= sum7[FB +: VW];
    end
  end

  assign out_valid_o   = v7_q;
  assign pixel_value_o = pix7_q;
  assign pixel_x_o     = cx7_q;
  assign pixel_y_o     = cy7_q;

endmodule

>>> tb/bilinear_grid_resampler_top_tb.sv
// testbench for the bilinear grid resampler: queued stimulus, in-order pixel checks
`timescale 1ns / 100ps

module bilinear_grid_resampler_top_tb;

  localparam int CFG_IDX_W = bgr_pkg::CFG_IDX_W;
  localparam int COORD_W = bgr_pkg::COORD_W;
  localparam int VAL_W = bgr_pkg::VAL_W;
  localparam int DW_W = bgr_pkg::DW_W;
  localparam int SW_W = bgr_pkg::SW_W;
  localparam int MAX_SRC_W = bgr_pkg::MAX_SRC_W;
  localparam int MAX_SRC_H = bgr_pkg::MAX_SRC_H;
  localparam int FRAC_BITS = bgr_pkg::FRAC_BITS;

  localparam logic CMD_PIXEL = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
  localparam int GRID_DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam longint ONE_FX = longint'(1) << FRAC_BITS;

  typedef struct {
    logic               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [VAL_W-1:0]   v;
  } grid_item_t;

  typedef struct {
    logic [VAL_W-1:0]   v;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pixel_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [DW_W-1:0]      data;
  } reg_write_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DW_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic command_i;
  logic [COORD_W-1:0] coord_x_i, coord_y_i;
  logic signed [VAL_W-1:0] sample_value_i;
  logic out_valid_o, out_stall_i;
  logic signed [VAL_W-1:0] pixel_value_o;
  logic [COORD_W-1:0] pixel_x_o, pixel_y_o;

  bilinear_grid_resampler_top dut (.*);

  // predictor state
  logic [VAL_W-1:0] grid_mem [GRID_DEPTH];
  logic [DW_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  // generator side: which entries will have been loaded
  bit loaded [GRID_DEPTH];

  grid_item_t pend_q[$];
  pixel_t pixel_q[$];
  reg_write_t regw_q[$];
  grid_item_t cur_item;
  reg_write_t cur_regw;
  int items_pushed, items_taken, regw_pushed, regw_done;
  int send_idle, recv_stall, errors;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // source neighbourhood of a destination coordinate under the current sizes
  function automatic void locate(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                                 output int x0, output int x1, output int y0, output int y1,
                                 output longint fx, output longint fy);
    longint sw, sh, dw, dh, sx, sy;
    sw = (src_w_reg[SW_W-1:0] == 0) ? 1 : longint'(src_w_reg[SW_W-1:0]);
    sh = (src_h_reg[SW_W-1:0] == 0) ? 1 : longint'(src_h_reg[SW_W-1:0]);
    if (sw > MAX_SRC_W) sw = MAX_SRC_W;
    if (sh > MAX_SRC_H) sh = MAX_SRC_H;
    dw = (dst_w_reg == 0) ? 1 : longint'(dst_w_reg);
    dh = (dst_h_reg == 0) ? 1 : longint'(dst_h_reg);
    sx = longint'(cx) * ((sw << FRAC_BITS) / dw);
    sy = longint'(cy) * ((sh << FRAC_BITS) / dh);
    fx = sx & (ONE_FX - 1);
    fy = sy & (ONE_FX - 1);
    x0 = int'((sx >> FRAC_BITS) > sw - 1 ? sw - 1 : sx >> FRAC_BITS);
    y0 = int'((sy >> FRAC_BITS) > sh - 1 ? sh - 1 : sy >> FRAC_BITS);
    x1 = (x0 + 1 > sw - 1) ? int'(sw - 1) : x0 + 1;
    y1 = (y0 + 1 > sh - 1) ? int'(sh - 1) : y0 + 1;
  endfunction

  function automatic logic [VAL_W-1:0] interpolate(input logic [COORD_W-1:0] cx,
                                                   input logic [COORD_W-1:0] cy);
    int x0, x1, y0, y1;
    longint fx, fy, sum, v00, v01, v10, v11;
    locate(cx, cy, x0, x1, y0, y1, fx, fy);
    v00 = $signed(grid_mem[y0 * MAX_SRC_W + x0]);
    v01 = $signed(grid_mem[y1 * MAX_SRC_W + x0]);
    v10 = $signed(grid_mem[y0 * MAX_SRC_W + x1]);
    v11 = $signed(grid_mem[y1 * MAX_SRC_W + x1]);
    sum = v00 * (((ONE_FX - fx) * (ONE_FX - fy)) >> FRAC_BITS)
        + v01 * (((ONE_FX - fx) * fy) >> FRAC_BITS)
        + v10 * ((fx * (ONE_FX - fy)) >> FRAC_BITS)
        + v11 * ((fx * fy) >> FRAC_BITS);
    sum = sum >>> FRAC_BITS;
    return sum[VAL_W-1:0];
  endfunction

  task automatic add_load(input int x, input int y, input logic [VAL_W-1:0] v);
    grid_item_t it;
    it.cmd = bgr_pkg::CMD_LOAD;
    it.x = COORD_W'(x);
    it.y = COORD_W'(y);
    it.v = v;
    if (x < MAX_SRC_W && y < MAX_SRC_H) loaded[y * MAX_SRC_W + x] = 1'b1;
    pend_q.push_back(it);
    items_pushed++;
  endtask

  // loads any neighbour not yet written, then the request itself
  task automatic add_pixel(input int x, input int y);
    grid_item_t it;
    int x0, x1, y0, y1;
    longint fx, fy;
    locate(COORD_W'(x), COORD_W'(y), x0, x1, y0, y1, fx, fy);
    if (!loaded[y0 * MAX_SRC_W + x0]) add_load(x0, y0, $urandom);
    if (!loaded[y1 * MAX_SRC_W + x0]) add_load(x0, y1, $urandom);
    if (!loaded[y0 * MAX_SRC_W + x1]) add_load(x1, y0, $urandom);
    if (!loaded[y1 * MAX_SRC_W + x1]) add_load(x1, y1, $urandom);
    it.cmd = CMD_PIXEL;
    it.x = COORD_W'(x);
    it.y = COORD_W'(y);
    it.v = $urandom;
    pend_q.push_back(it);
    items_pushed++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    reg_write_t w;
    w.idx = idx;
    w.data = DW_W'(data);
    regw_q.push_back(w);
    regw_pushed++;
  endtask

  task automatic drain();
    while (items_taken != items_pushed || pixel_q.size() != 0 || regw_done != regw_pushed)
      @(posedge clk_i);
    // loads leave no result, so let the pipe empty before touching registers
    repeat (12) @(posedge clk_i);
  endtask

  task automatic add_random(input int count);
    int dw, dh, sw, sh;
    sw = (src_w_reg[SW_W-1:0] == 0) ? 1 : int'(src_w_reg[SW_W-1:0]);
    sh = (src_h_reg[SW_W-1:0] == 0) ? 1 : int'(src_h_reg[SW_W-1:0]);
    if (sw > MAX_SRC_W) sw = MAX_SRC_W;
    if (sh > MAX_SRC_H) sh = MAX_SRC_H;
    dw = (dst_w_reg == 0) ? 1 : int'(dst_w_reg);
    dh = (dst_h_reg == 0) ? 1 : int'(dst_h_reg);
    if (dw > 4096) dw = 4096;
    if (dh > 4096) dh = 4096;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2: add_load($urandom_range(sw - 1), $urandom_range(sh - 1), $urandom);
        3: add_load($urandom_range(4095), $urandom_range(4095), $urandom);
        4: add_pixel($urandom_range(4095), $urandom_range(4095));
        default: add_pixel($urandom_range(dw - 1), $urandom_range(dh - 1));
      endcase
    end
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      items_taken++;
      if (cur_item.cmd == bgr_pkg::CMD_LOAD) begin
        if (cur_item.x < MAX_SRC_W && cur_item.y < MAX_SRC_H)
          grid_mem[cur_item.y * MAX_SRC_W + cur_item.x] = cur_item.v;
      end else begin
        pixel_q.push_back('{interpolate(cur_item.x, cur_item.y), cur_item.x, cur_item.y});
      end
    end
    if (!in_valid_i || !in_stall_o) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        cur_item = pend_q.pop_front();
        in_valid_i <= 1'b1;
        command_i <= cur_item.cmd;
        coord_x_i <= cur_item.x;
        coord_y_i <= cur_item.y;
        sample_value_i <= cur_item.v;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // register write driver
  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) begin
      case (cur_regw.idx)
        bgr_pkg::CFG_SRC_W: src_w_reg = cur_regw.data & DW_W'(9'h1FF);
        bgr_pkg::CFG_SRC_H: src_h_reg = cur_regw.data & DW_W'(9'h1FF);
        bgr_pkg::CFG_DST_W: dst_w_reg = cur_regw.data;
        bgr_pkg::CFG_DST_H: dst_h_reg = cur_regw.data;
        default: ;
      endcase
      regw_done++;
    end
    if (!cfg_valid_i || cfg_ready_o) begin
      if (regw_q.size() != 0) begin
        cur_regw = regw_q.pop_front();
        cfg_valid_i <= 1'b1;
        cfg_index_i <= cur_regw.idx;
        cfg_data_i <= cur_regw.data;
      end else begin
        cfg_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    pixel_t e;
    if (out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        report($sformatf("unexpected pixel (%0d,%0d)", pixel_x_o, pixel_y_o));
      end else begin
        e = pixel_q.pop_front();
        if (pixel_value_o !== e.v)
          report($sformatf("pixel_value %h, want %h at (%0d,%0d)", pixel_value_o, e.v, e.x, e.y));
        if (pixel_x_o !== e.x) report($sformatf("pixel_x %0d, want %0d", pixel_x_o, e.x));
        if (pixel_y_o !== e.y) report($sformatf("pixel_y %0d, want %0d", pixel_y_o, e.y));
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall);
  end

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("bilinear_grid_resampler_top_tb: FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = bgr_pkg::CMD_LOAD;
    coord_x_i = '0;
    coord_y_i = '0;
    sample_value_i = '0;
    out_stall_i = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    errors = 0;
    src_w_reg = DW_W'(256);
    src_h_reg = DW_W'(256);
    dst_w_reg = DW_W'(256);
    dst_h_reg = DW_W'(256);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset sizes, value and coordinate extremes
    add_load(0, 0, 32'h7FFF_FFFF);
    add_load(1, 0, 32'h8000_0000);
    add_load(0, 1, 32'hFFFF_FFFF);
    add_load(1, 1, 32'h0001_0000);
    add_pixel(0, 0);
    add_load(255, 255, 32'h8000_0000);
    add_load(4095, 4095, 32'h1234_5678);
    add_load(256, 3, 32'h5555_5555);
    add_load(3, 256, 32'hAAAA_AAAA);
    add_pixel(255, 255);
    add_pixel(4095, 4095);
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    add_pixel(2730, 1365);
    drain();
    // odd ratios with fraction bits, unknown indexes ignored
    write_reg(bgr_pkg::CFG_SRC_W, 3);
    write_reg(bgr_pkg::CFG_SRC_H, 5);
    write_reg(bgr_pkg::CFG_DST_W, 7);
    write_reg(bgr_pkg::CFG_DST_H, 11);
    write_reg(CFG_UNUSED_LO, 1);
    write_reg(CFG_UNUSED_HI, 8191);
    drain();
    add_load(0, 0, 32'h7FFF_FFFF);
    add_load(1, 0, 32'h7FFF_FFFF);
    add_load(0, 1, 32'h7FFF_FFFF);
    add_load(1, 1, 32'h7FFF_FFFF);
    add_pixel(1, 1);
    add_pixel(6, 10);
    add_pixel(3, 4);
    add_random(70);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin  // smallest sizes
          write_reg(bgr_pkg::CFG_SRC_W, 1); write_reg(bgr_pkg::CFG_SRC_H, 1);
          write_reg(bgr_pkg::CFG_DST_W, 1); write_reg(bgr_pkg::CFG_DST_H, 1);
        end
        1: begin  // largest sizes
          write_reg(bgr_pkg::CFG_SRC_W, 256); write_reg(bgr_pkg::CFG_SRC_H, 256);
          write_reg(bgr_pkg::CFG_DST_W, 4096); write_reg(bgr_pkg::CFG_DST_H, 4096);
        end
        2: begin  // zero acts as one, oversize source saturates, high bits dropped
          write_reg(bgr_pkg::CFG_SRC_W, 0); write_reg(bgr_pkg::CFG_SRC_H, 511);
          write_reg(bgr_pkg::CFG_DST_W, 0); write_reg(bgr_pkg::CFG_DST_H, 13'h1005);
          write_reg(bgr_pkg::CFG_SRC_W, 13'h1E05);
        end
        3: begin  // shrink
          write_reg(bgr_pkg::CFG_SRC_W, 256); write_reg(bgr_pkg::CFG_SRC_H, 200);
          write_reg(bgr_pkg::CFG_DST_W, 1); write_reg(bgr_pkg::CFG_DST_H, 3);
        end
        default: begin
          write_reg(bgr_pkg::CFG_SRC_W, $urandom_range(2, 16));
          write_reg(bgr_pkg::CFG_SRC_H, $urandom_range(1, 16));
          write_reg(bgr_pkg::CFG_DST_W, $urandom_range(1, 64));
          write_reg(bgr_pkg::CFG_DST_H, $urandom_range(1, 64));
        end
      endcase
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 63; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 63; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      drain();
      add_random(35);
      if (ph == 7) begin
        // hold back the second batch until every item is taken and every pixel is out
        while (items_taken != items_pushed || pixel_q.size() != 0) @(posedge clk_i);
      end
      add_random(35);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (pixel_q.size() != 0) report($sformatf("%0d pixels never came", pixel_q.size()));
    if (errors == 0) begin
      $display("bilinear_grid_resampler_top_tb: PASS");
    end else begin
      $display("bilinear_grid_resampler_top_tb: FAIL");
    end
    $finish;
  end

endmodule
